>>> hw/rtl/arwm_pkg.sv
`default_nettype none
package arwm_pkg;

	// event codes on the input channel
	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_END    = 2'd2
	} arwm_kind_t;

	// operations of the shared end-of-window datapath
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_NS2  = 3'd1,
		OP_S1SQ = 3'd2,
		OP_DEN  = 3'd3,
		OP_DIV  = 3'd4,
		OP_SQRT = 3'd5
	} arwm_op_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_LOAD  = 3'd1,
		ST_NS2   = 3'd2,
		ST_S1SQ  = 3'd3,
		ST_DEN   = 3'd4,
		ST_DIV   = 3'd5,
		ST_SQRT  = 3'd6,
		ST_EMPTY = 3'd7
	} arwm_state_t;

	typedef struct packed {
		logic     accept;
		arwm_op_t load;
		logic     step;
		logic     finish;
	} arwm_cmd_t;

	typedef struct packed {
		logic kind_end;
		logic win_open;
		logic count_zero;
		logic step_done;
		logic out_free;
	} arwm_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/arwm_in_if.sv
`default_nettype none
interface arwm_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          sample_valid;

	modport source (output valid, kind, sample_value, sample_valid, input ready);
	modport sink   (input valid, kind, sample_value, sample_valid, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/arwm_out_if.sv
`default_nettype none
interface arwm_out_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 20
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] rms_ac;
	logic [COUNT_BITS-1:0]  sample_count;
	logic                   empty_window;
	logic                   count_saturated;

	modport source (output valid, rms_ac, sample_count, empty_window, count_saturated,
		input ready);
	modport sink   (input valid, rms_ac, sample_count, empty_window, count_saturated,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ac_rms_window_meter.sv
// AC RMS window meter. A start event opens a window and clears its sample
// count N, sum S1 and sum of squares S2; valid samples inside the open window
// are accumulated one per cycle, and once N reaches its all-ones maximum further
// samples are dropped and the saturation flag is set. An end event on an open
// window closes it and delivers one result, floor(sqrt(floor((N*S2-S1^2)/N^2))),
// with the count and flags; an end event with no open window, and event code 3,
// do nothing. Start and sample events never stall the input themselves. An end
// event on a non-empty window keeps the input stalled while one shift-add
// multiplier forms N*S2, S1^2 and N^2 one bit per cycle, a restoring divider
// produces one quotient bit per cycle over the whole numerator, and the square
// root resolves one result bit per cycle. An empty window skips the computation
// and reports a zero RMS. The result sits in an output register, so samples
// keep flowing while it waits; only another end event waits for that register
// to drain.
`default_nettype none
module ac_rms_window_meter #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 20
) (
	input wire logic   clk,
	input wire logic   arst_n,
	arwm_in_if.sink    item,
	arwm_out_if.source result
);
	import arwm_pkg::*;

	arwm_cmd_t    cmd;
	arwm_status_t status;

	// sequencer for the end-of-window computation and the input handshake
	arwm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// accumulators, shared multiply/divide/sqrt unit and result register
	arwm_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.kind            (item.kind),
		.sample_value    (item.sample_value),
		.sample_valid    (item.sample_valid),
		.result_ready    (result.ready),
		.result_valid    (result.valid),
		.rms_ac          (result.rms_ac),
		.sample_count    (result.sample_count),
		.empty_window    (result.empty_window),
		.count_saturated (result.count_saturated)
	);

`ifndef SYNTH
	// a closing transfer on an open window must stall the input next cycle
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && status.kind_end && status.win_open) |=> !item.ready)
		else $error("input not stalled after window close");

	// the result register must be free whenever a new result is loaded
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !result.valid)
		else $error("result overwritten before transfer");

	// no input transfer while the shared unit is iterating
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.load != OP_NONE) |-> !item.ready)
		else $error("input accepted during computation");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/arwm_datapath.sv
`default_nettype none
module arwm_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire arwm_pkg::arwm_cmd_t           cmd,
	output arwm_pkg::arwm_status_t             status,
	input  wire logic [1:0]                    kind,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
	input  wire logic                          sample_valid,
	input  wire logic                          result_ready,
	output logic                               result_valid,
	output logic [SAMPLE_BITS-1:0]             rms_ac,
	output logic [COUNT_BITS-1:0]              sample_count,
	output logic                               empty_window,
	output logic                               count_saturated
);
	import arwm_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
	localparam int NUM_W = 2 * SAMPLE_BITS - 1 + 2 * COUNT_BITS;
	localparam int DEN_W = 2 * COUNT_BITS;
	localparam int Q_W   = 2 * SAMPLE_BITS - 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	// window accumulators
	logic                    open_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         s2_q;
	logic                    sat_q;
	logic [2*SB-1:0]         sq_s1;
	logic                    sq_vld_s1;
	logic                    take_sample;
	logic                    start_take;

	logic [SB-1:0]           samp_u;
	logic [SB-1:0]           mag;
	logic [SUM_W-1:0]        sum_u;
	logic [SUM_W-1:0]        s1_mag;

	// end-of-window unit
	arwm_op_t                op_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NUM_W-1:0]        acc_q;
	logic [NUM_W-1:0]        mcand_q;
	logic [SUM_W-1:0]        mplier_q;
	logic [NUM_W-1:0]        ns2_q;
	logic [NUM_W-1:0]        num_q;
	logic [NUM_W-1:0]        num_diff;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W:0]          rem_sh;
	logic                    div_ge;
	logic [DEN_W-1:0]        rem_nx;
	logic [Q_W-1:0]          quo_q;
	logic [Q_W-1:0]          rad_q;
	logic [Q_W-1:0]          root_q;
	logic [Q_W-1:0]          bit_q;
	logic [Q_W:0]            trial;
	logic                    sqrt_ge;
	logic                    out_valid_q;

	assign samp_u = sample_value;
	assign mag    = samp_u[SB-1] ? (~samp_u + 1'b1) : samp_u;
	assign sum_u  = sum_q;
	assign s1_mag = sum_u[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

	// a sample that really lands in the window
	assign take_sample = cmd.accept && (kind == KIND_SAMPLE) && open_q && sample_valid
		&& (count_q != '1);
	assign start_take  = cmd.accept && (kind == KIND_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			count_q   <= '0;
			sum_q     <= '0;
			s2_q      <= '0;
			sat_q     <= 1'b0;
			sq_vld_s1 <= 1'b0;
		end else begin
			sq_vld_s1 <= take_sample;
			// a start drops a square still in flight
			if (start_take) begin
				s2_q <= '0;
			end else if (sq_vld_s1) begin
				s2_q <= s2_q + SQ_W'(sq_s1);
			end
			if (cmd.accept) begin
				case (kind)
					KIND_START: begin
						open_q  <= 1'b1;
						count_q <= '0;
						sum_q   <= '0;
						sat_q   <= 1'b0;
					end
					KIND_SAMPLE: begin
						if (open_q && sample_valid) begin
							if (count_q == '1) begin
								sat_q <= 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
								sum_q   <= sum_q + SUM_W'(sample_value);
							end
						end
					end
					KIND_END: begin
						open_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= mag * mag;
	end

	assign num_diff = (acc_q > ns2_q) ? '0 : (ns2_q - acc_q);

	// restoring divide step
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign div_ge = (rem_sh >= {1'b0, den_q});
	assign rem_nx = div_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];

	// digit-by-digit square root step
	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign sqrt_ge = ({1'b0, rad_q} >= trial);

	always_ff @(posedge clk) begin
		case (cmd.load)
			OP_NS2: begin
				op_q     <= OP_NS2;
				acc_q    <= '0;
				mcand_q  <= NUM_W'(s2_q);
				mplier_q <= SUM_W'(count_q);
				cnt_q    <= CNT_W'(COUNT_BITS);
			end
			OP_S1SQ: begin
				op_q     <= OP_S1SQ;
				ns2_q    <= acc_q;
				acc_q    <= '0;
				mcand_q  <= NUM_W'(s1_mag);
				mplier_q <= s1_mag;
				cnt_q    <= CNT_W'(SUM_W);
			end
			OP_DEN: begin
				op_q     <= OP_DEN;
				num_q    <= num_diff;
				acc_q    <= '0;
				mcand_q  <= NUM_W'(count_q);
				mplier_q <= SUM_W'(count_q);
				cnt_q    <= CNT_W'(COUNT_BITS);
			end
			OP_DIV: begin
				op_q  <= OP_DIV;
				den_q <= acc_q[DEN_W-1:0];
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CNT_W'(NUM_W);
			end
			OP_SQRT: begin
				op_q   <= OP_SQRT;
				rad_q  <= quo_q;
				root_q <= '0;
				bit_q  <= {1'b1, {(Q_W-1){1'b0}}};
				cnt_q  <= CNT_W'(SAMPLE_BITS);
			end
			default: begin
				if (cmd.step) begin
					cnt_q <= cnt_q - 1'b1;
					case (op_q)
						OP_NS2, OP_S1SQ, OP_DEN: begin
							if (mplier_q[0]) begin
								acc_q <= acc_q + mcand_q;
							end
							mcand_q  <= mcand_q << 1;
							mplier_q <= mplier_q >> 1;
						end
						OP_DIV: begin
							rem_q <= rem_nx;
							num_q <= num_q << 1;
							quo_q <= {quo_q[Q_W-2:0], div_ge};
						end
						OP_SQRT: begin
							if (sqrt_ge) begin
								rad_q  <= rad_q - trial[Q_W-1:0];
								root_q <= (root_q >> 1) + bit_q;
							end else begin
								root_q <= root_q >> 1;
							end
							bit_q <= bit_q >> 2;
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rms_ac          <= (count_q == '0) ? '0 : root_q[SB-1:0];
			sample_count    <= count_q;
			empty_window    <= (count_q == '0);
			count_saturated <= sat_q;
		end
	end

	assign result_valid      = out_valid_q;
	assign status.kind_end   = (kind == KIND_END);
	assign status.win_open   = open_q;
	assign status.count_zero = (count_q == '0);
	assign status.step_done  = (cnt_q == '0);
	assign status.out_free   = !out_valid_q || result_ready;

endmodule
`default_nettype wire

>>> hw/rtl/arwm_ctrl.sv
`default_nettype none
module arwm_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire arwm_pkg::arwm_status_t status,
	output arwm_pkg::arwm_cmd_t         cmd
);
	import arwm_pkg::*;

	arwm_state_t state_q;
	arwm_state_t state_nx;
	logic        end_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// a closing event on an open window starts the computation
	assign end_go = item_valid && item_ready && status.kind_end && status.win_open;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (end_go) begin
					state_nx = status.count_zero ? ST_EMPTY : ST_LOAD;
				end
			end
			ST_LOAD:  state_nx = ST_NS2;
			ST_NS2:   if (status.step_done) state_nx = ST_S1SQ;
			ST_S1SQ:  if (status.step_done) state_nx = ST_DEN;
			ST_DEN:   if (status.step_done) state_nx = ST_DIV;
			ST_DIV:   if (status.step_done) state_nx = ST_SQRT;
			ST_SQRT:  if (status.step_done) state_nx = ST_IDLE;
			ST_EMPTY: state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd        = '{accept: 1'b0, load: OP_NONE, step: 1'b0, finish: 1'b0};
		case (state_q)
			ST_IDLE: begin
				item_ready = status.out_free || !status.kind_end;
				cmd.accept = item_valid && item_ready;
			end
			ST_LOAD: cmd.load = OP_NS2;
			ST_NS2: begin
				if (status.step_done) cmd.load = OP_S1SQ;
				else cmd.step = 1'b1;
			end
			ST_S1SQ: begin
				if (status.step_done) cmd.load = OP_DEN;
				else cmd.step = 1'b1;
			end
			ST_DEN: begin
				if (status.step_done) cmd.load = OP_DIV;
				else cmd.step = 1'b1;
			end
			ST_DIV: begin
				if (status.step_done) cmd.load = OP_SQRT;
				else cmd.step = 1'b1;
			end
			ST_SQRT: begin
				if (status.step_done) cmd.finish = 1'b1;
				else cmd.step = 1'b1;
			end
			ST_EMPTY: cmd.finish = 1'b1;
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
